// ===== rtl/core/tfnt_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle face normal and tangent: shared package
// Constants, widths, command and status types used by the controller,
// the datapath and the top level.
// ----------------------------------------------------------------------------
package tfnt_pkg;

  localparam int OUT_FRAC_BITS_DEF = 14;

  localparam int POS_W   = 32;
  localparam int EDGE_W  = 33;
  localparam int PROD_W  = 66;
  localparam int ACC_W   = 67;
  localparam int NORM_W  = 30;
  localparam int SQ_W    = 62;
  localparam int LEN_W   = 32;
  localparam int DIV_W   = 62;
  localparam int OUT_W   = 16;

  localparam int MUL_STEPS  = 14;
  localparam int SQ_STEPS   = 3;
  localparam int SQRT_ITERS = 31;
  localparam int CNT_W      = 6;

  localparam logic [SQ_W-1:0] SQRT_BIT0 = {2'b01, {(SQ_W-2){1'b0}}};

  localparam logic [1:0] CORNER_LAST = 2'd2;

  localparam logic [1:0] MK_NONE   = 2'd0;
  localparam logic [1:0] MK_CROSS  = 2'd1;
  localparam logic [1:0] MK_SQUARE = 2'd2;

  localparam logic VSEL_NORMAL  = 1'b0;
  localparam logic VSEL_TANGENT = 1'b1;

  typedef struct packed {
    logic       hold_wr;
    logic       load;
    logic       mul_go;
    logic [3:0] mul_step;
    logic       vsel;
    logic       nload;
    logic       shift;
    logic       sq_go;
    logic [1:0] sq_idx;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic [1:0] comp;
    logic       comp_wr;
    logic       zero_vec;
    logic       publish;
  } tfnt_cmd_t;

  typedef struct packed {
    logic det_zero;
    logic vec_zero;
    logic vec_top;
  } tfnt_status_t;

endpackage

// ===== rtl/core/triangle_face_normal_tangent_unit.sv =====
// ----------------------------------------------------------------------------
// Triangle face normal and tangent unit
// Takes three triangle corners one request at a time and returns the unit
// face normal, the unit tangent with handedness, and degenerate flags.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in_      input      in_valid/in_stall    corner, pos_x/y/z, tex_u/v
//  out_     output     out_valid/out_stall  normal, tangent, flags
//
// Corners 0 and 1 are held; corner 3 is dropped.
// Corner 2 starts the computation, which runs the normalizer with up to nine
// shifts per vector, the 31-step square root and the bit-serial divider.
// Reset is synchronous and clears only control state.
// A stalled result is held while the unit accepts corners 0 and 1.
// ----------------------------------------------------------------------------
module triangle_face_normal_tangent_unit #(
  parameter int OUT_FRAC_BITS = tfnt_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_corner,
  input  logic signed [31:0]  in_pos_x,
  input  logic signed [31:0]  in_pos_y,
  input  logic signed [31:0]  in_pos_z,
  input  logic signed [31:0]  in_tex_u,
  input  logic signed [31:0]  in_tex_v,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_normal_x,
  output logic signed [15:0]  out_normal_y,
  output logic signed [15:0]  out_normal_z,
  output logic signed [15:0]  out_tangent_x,
  output logic signed [15:0]  out_tangent_y,
  output logic signed [15:0]  out_tangent_z,
  output logic                out_flipped,
  output logic                out_normal_degenerate,
  output logic                out_tangent_degenerate
);

  tfnt_pkg::tfnt_cmd_t    cmd;
  tfnt_pkg::tfnt_status_t status;

  tfnt_ctrl #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_corner (in_corner),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tfnt_dp #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .status                 (status),
    .in_corner              (in_corner),
    .in_pos_x               (in_pos_x),
    .in_pos_y               (in_pos_y),
    .in_pos_z               (in_pos_z),
    .in_tex_u               (in_tex_u),
    .in_tex_v               (in_tex_v),
    .out_normal_x           (out_normal_x),
    .out_normal_y           (out_normal_y),
    .out_normal_z           (out_normal_z),
    .out_tangent_x          (out_tangent_x),
    .out_tangent_y          (out_tangent_y),
    .out_tangent_z          (out_tangent_z),
    .out_flipped            (out_flipped),
    .out_normal_degenerate  (out_normal_degenerate),
    .out_tangent_degenerate (out_tangent_degenerate)
  );

endmodule

// ===== rtl/core/tfnt_dp.sv =====
// ----------------------------------------------------------------------------
// Triangle face normal and tangent: datapath
// Held corners, edge deltas, shared multiplier with accumulators, vector
// normalizer, bit-serial square root, restoring divider and result registers.
// ----------------------------------------------------------------------------
module tfnt_dp #(
  parameter int OUT_FRAC_BITS = tfnt_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tfnt_pkg::tfnt_cmd_t         cmd,
  output tfnt_pkg::tfnt_status_t      status,
  input  logic [1:0]                  in_corner,
  input  logic signed [31:0]          in_pos_x,
  input  logic signed [31:0]          in_pos_y,
  input  logic signed [31:0]          in_pos_z,
  input  logic signed [31:0]          in_tex_u,
  input  logic signed [31:0]          in_tex_v,
  output logic signed [15:0]          out_normal_x,
  output logic signed [15:0]          out_normal_y,
  output logic signed [15:0]          out_normal_z,
  output logic signed [15:0]          out_tangent_x,
  output logic signed [15:0]          out_tangent_y,
  output logic signed [15:0]          out_tangent_z,
  output logic                        out_flipped,
  output logic                        out_normal_degenerate,
  output logic                        out_tangent_degenerate
);

  localparam int QW    = OUT_FRAC_BITS + 1;
  localparam int EW    = tfnt_pkg::EDGE_W;
  localparam int AW    = tfnt_pkg::ACC_W;
  localparam int PW    = tfnt_pkg::PROD_W;
  localparam int NW    = tfnt_pkg::NORM_W;
  localparam int SW    = tfnt_pkg::SQ_W;
  localparam int DW    = tfnt_pkg::DIV_W;
  localparam int OW    = tfnt_pkg::OUT_W;
  localparam int LW    = tfnt_pkg::LEN_W;

  logic signed [31:0]   pos_r [2][3];
  logic signed [31:0]   tex_r [2][2];
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic signed [EW-1:0] du1_r, dv1_r, du2_r, dv2_r;

  logic signed [EW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_r;
  logic [1:0]           kind_r;
  logic [3:0]           step_r;

  logic signed [AW-1:0] acc_r [7];
  logic [AW-1:0]        m_r [3];
  logic                 neg_r [3];
  logic [AW-1:0]        or_all;
  logic [NW-1:0]        csq;
  logic [NW-1:0]        cdiv;

  logic [SW-1:0]        s_r;
  logic [SW-1:0]        sn_r, sr_r, sb_r;
  logic [SW-1:0]        sq_t;
  logic [LW-1:0]        len;

  logic [DW-1:0]        rem_r, dv_r;
  logic [QW-1:0]        q_r;
  logic [QW-1:0]        q_clamp;
  logic [31:0]          q_ext;
  logic [31:0]          q_sgn;

  logic [OW-1:0]        res_r [2][3];

  logic signed [EW-1:0] p0 [3];
  logic signed [EW-1:0] in_p [3];

  always_comb begin
    in_p[0] = EW'(in_pos_x);
    in_p[1] = EW'(in_pos_y);
    in_p[2] = EW'(in_pos_z);
    for (int i = 0; i < 3; i++) begin
      p0[i] = EW'(pos_r[0][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_wr) begin
      pos_r[in_corner[0]][0] <= in_pos_x;
      pos_r[in_corner[0]][1] <= in_pos_y;
      pos_r[in_corner[0]][2] <= in_pos_z;
      tex_r[in_corner[0]][0] <= in_tex_u;
      tex_r[in_corner[0]][1] <= in_tex_v;
    end
    if (cmd.load) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= EW'(pos_r[1][i]) - p0[i];
        e2_r[i] <= in_p[i] - p0[i];
      end
      du1_r <= EW'(tex_r[1][0]) - EW'(tex_r[0][0]);
      dv1_r <= EW'(tex_r[1][1]) - EW'(tex_r[0][1]);
      du2_r <= EW'(in_tex_u) - EW'(tex_r[0][0]);
      dv2_r <= EW'(in_tex_v) - EW'(tex_r[0][1]);
    end
  end

  assign csq  = m_r[cmd.sq_idx][AW-1 -: NW];
  assign cdiv = m_r[cmd.comp][AW-1 -: NW];

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (cmd.sq_go) begin
      op_a = EW'(csq);
      op_b = EW'(csq);
    end else begin
      case (cmd.mul_step)
        4'd0:    begin op_a = e1_r[1]; op_b = e2_r[2]; end
        4'd1:    begin op_a = e1_r[2]; op_b = e2_r[1]; end
        4'd2:    begin op_a = e1_r[2]; op_b = e2_r[0]; end
        4'd3:    begin op_a = e1_r[0]; op_b = e2_r[2]; end
        4'd4:    begin op_a = e1_r[0]; op_b = e2_r[1]; end
        4'd5:    begin op_a = e1_r[1]; op_b = e2_r[0]; end
        4'd6:    begin op_a = du1_r;   op_b = dv2_r;   end
        4'd7:    begin op_a = du2_r;   op_b = dv1_r;   end
        4'd8:    begin op_a = dv1_r;   op_b = e2_r[0]; end
        4'd9:    begin op_a = dv2_r;   op_b = e1_r[0]; end
        4'd10:   begin op_a = dv1_r;   op_b = e2_r[1]; end
        4'd11:   begin op_a = dv2_r;   op_b = e1_r[1]; end
        4'd12:   begin op_a = dv1_r;   op_b = e2_r[2]; end
        4'd13:   begin op_a = dv2_r;   op_b = e1_r[2]; end
        default: begin op_a = '0;      op_b = '0;      end
      endcase
    end
  end

  assign prod = op_a * op_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= tfnt_pkg::MK_NONE;
    end else if (cmd.sq_go) begin
      kind_r <= tfnt_pkg::MK_SQUARE;
    end else if (cmd.mul_go) begin
      kind_r <= tfnt_pkg::MK_CROSS;
    end else begin
      kind_r <= tfnt_pkg::MK_NONE;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod;
    step_r <= cmd.mul_step;
    if (kind_r == tfnt_pkg::MK_CROSS) begin
      if (step_r[0]) begin
        acc_r[step_r[3:1]] <= acc_r[step_r[3:1]] - AW'(prod_r);
      end else begin
        acc_r[step_r[3:1]] <= AW'(prod_r);
      end
    end
  end

  assign or_all = m_r[0] | m_r[1] | m_r[2];

  always_ff @(posedge clk) begin
    if (cmd.nload) begin
      for (int i = 0; i < 3; i++) begin
        neg_r[i] <= acc_r[cmd.vsel ? 4 + i : i][AW-1];
        m_r[i]   <= acc_r[cmd.vsel ? 4 + i : i][AW-1] ?
                    AW'(-acc_r[cmd.vsel ? 4 + i : i]) : AW'(acc_r[cmd.vsel ? 4 + i : i]);
      end
    end else if (cmd.shift) begin
      for (int i = 0; i < 3; i++) begin
        if (or_all[AW-1 -: 16] == '0) begin
          m_r[i] <= m_r[i] << 16;
        end else if (or_all[AW-1 -: 4] == '0) begin
          m_r[i] <= m_r[i] << 4;
        end else begin
          m_r[i] <= m_r[i] << 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.nload) begin
      s_r <= '0;
    end else if (kind_r == tfnt_pkg::MK_SQUARE) begin
      s_r <= s_r + prod_r[SW-1:0];
    end
  end

  assign sq_t = sr_r + sb_r;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sn_r <= s_r;
      sr_r <= '0;
      sb_r <= tfnt_pkg::SQRT_BIT0;
    end else if (cmd.sqrt_step) begin
      if (sn_r >= sq_t) begin
        sn_r <= sn_r - sq_t;
        sr_r <= (sr_r >> 1) + sb_r;
      end else begin
        sr_r <= sr_r >> 1;
      end
      sb_r <= sb_r >> 2;
    end
  end

  assign len = sr_r[LW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= (DW'(cdiv) << OUT_FRAC_BITS) + DW'(len[LW-1:1]);
      dv_r  <= DW'(len) << OUT_FRAC_BITS;
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (rem_r >= dv_r) begin
        rem_r <= rem_r - dv_r;
        q_r   <= {q_r[QW-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QW-2:0], 1'b0};
      end
      dv_r <= dv_r >> 1;
    end
  end

  assign q_clamp = (q_r > (QW'(1) << OUT_FRAC_BITS)) ? (QW'(1) << OUT_FRAC_BITS) : q_r;
  assign q_ext   = 32'(q_clamp);
  assign q_sgn   = neg_r[cmd.comp] ? (32'd0 - q_ext) : q_ext;

  always_ff @(posedge clk) begin
    if (cmd.zero_vec) begin
      for (int i = 0; i < 3; i++) begin
        res_r[cmd.vsel][i] <= '0;
      end
    end else if (cmd.comp_wr) begin
      res_r[cmd.vsel][cmd.comp] <= q_sgn[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_normal_x           <= res_r[0][0];
      out_normal_y           <= res_r[0][1];
      out_normal_z           <= res_r[0][2];
      out_tangent_x          <= res_r[1][0];
      out_tangent_y          <= res_r[1][1];
      out_tangent_z          <= res_r[1][2];
      out_normal_degenerate  <= (acc_r[0] == '0) && (acc_r[1] == '0) && (acc_r[2] == '0);
      out_tangent_degenerate <= (acc_r[3] == '0);
      out_flipped            <= (acc_r[3] != '0) && !acc_r[3][AW-1];
    end
  end

  assign status.det_zero = (acc_r[3] == '0);
  assign status.vec_zero = (or_all == '0);
  assign status.vec_top  = or_all[AW-1];

endmodule

// ===== rtl/core/tfnt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Triangle face normal and tangent: controller
// Sequences the multiplier, the normalizer, the square root and the divider
// for the normal and then the tangent, and owns both handshakes.
// ----------------------------------------------------------------------------
module tfnt_ctrl #(
  parameter int OUT_FRAC_BITS = tfnt_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_corner,
  output logic                    out_valid,
  input  logic                    out_stall,
  input  tfnt_pkg::tfnt_status_t  status,
  output tfnt_pkg::tfnt_cmd_t     cmd
);

  localparam int CW = tfnt_pkg::CNT_W;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_MUL       = 4'd1;
  localparam logic [3:0] ST_NLOAD     = 4'd2;
  localparam logic [3:0] ST_NSHIFT    = 4'd3;
  localparam logic [3:0] ST_SQ        = 4'd4;
  localparam logic [3:0] ST_SQRT_INIT = 4'd5;
  localparam logic [3:0] ST_SQRT      = 4'd6;
  localparam logic [3:0] ST_DIV_INIT  = 4'd7;
  localparam logic [3:0] ST_DIV       = 4'd8;
  localparam logic [3:0] ST_DIV_WR    = 4'd9;
  localparam logic [3:0] ST_NEXTV     = 4'd10;
  localparam logic [3:0] ST_OUT       = 4'd11;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          vsel_r, vsel_nxt;
  logic [1:0]    comp_r, comp_nxt;
  logic          out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    vsel_nxt  = vsel_r;
    comp_nxt  = comp_r;
    cmd       = '0;
    cmd.vsel  = vsel_r;
    cmd.comp  = comp_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_corner < tfnt_pkg::CORNER_LAST) begin
            cmd.hold_wr = 1'b1;
          end else if (in_corner == tfnt_pkg::CORNER_LAST) begin
            cmd.load  = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r < CW'(tfnt_pkg::MUL_STEPS)) begin
          cmd.mul_go   = 1'b1;
          cmd.mul_step = cnt_r[3:0];
        end else begin
          vsel_nxt  = tfnt_pkg::VSEL_NORMAL;
          state_nxt = ST_NLOAD;
        end
      end
      ST_NLOAD: begin
        cmd.nload = 1'b1;
        state_nxt = ST_NSHIFT;
      end
      ST_NSHIFT: begin
        if (status.vec_zero) begin
          cmd.zero_vec = 1'b1;
          state_nxt    = ST_NEXTV;
        end else if (status.vec_top) begin
          cnt_nxt   = '0;
          state_nxt = ST_SQ;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      ST_SQ: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r < CW'(tfnt_pkg::SQ_STEPS)) begin
          cmd.sq_go  = 1'b1;
          cmd.sq_idx = cnt_r[1:0];
        end else begin
          state_nxt = ST_SQRT_INIT;
        end
      end
      ST_SQRT_INIT: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CW'(tfnt_pkg::SQRT_ITERS - 1)) begin
          comp_nxt  = '0;
          state_nxt = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CW'(OUT_FRAC_BITS)) begin
          state_nxt = ST_DIV_WR;
        end
      end
      ST_DIV_WR: begin
        cmd.comp_wr = 1'b1;
        if (comp_r == 2'd2) begin
          state_nxt = ST_NEXTV;
        end else begin
          comp_nxt  = comp_r + 1'b1;
          state_nxt = ST_DIV_INIT;
        end
      end
      ST_NEXTV: begin
        if (vsel_r == tfnt_pkg::VSEL_NORMAL) begin
          if (status.det_zero) begin
            cmd.vsel     = tfnt_pkg::VSEL_TANGENT;
            cmd.zero_vec = 1'b1;
            state_nxt    = ST_OUT;
          end else begin
            vsel_nxt  = tfnt_pkg::VSEL_TANGENT;
            state_nxt = ST_NLOAD;
          end
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      vsel_r      <= tfnt_pkg::VSEL_NORMAL;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      vsel_r      <= vsel_nxt;
      comp_r      <= comp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_corner == tfnt_pkg::CORNER_LAST) |=> state_r == ST_MUL)
    else $error("Completing corner did not start the multiply sequence.");

  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> cnt_r <= CW'(OUT_FRAC_BITS))
    else $error("Divider ran past its last quotient bit.");

  a_publish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_valid_r)
    else $error("Published result is not offered.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT && out_valid_r && out_stall |=> state_r == ST_OUT)
    else $error("New result overwrote a stalled result.");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Triangle face normal and tangent unit: testbench
// Drives triangles corner by corner, and lone corners, with random idling on both sides.
// A built-in predictor computes the exact cross product, the UV determinant
// and the tangent vector and normalizes both vectors to Q1.14; every result is checked.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int FRAC = tfnt_pkg::OUT_FRAC_BITS_DEF;
  localparam int NORM_SHIFT = 30;

  typedef struct packed {
    logic signed [15:0] nx, ny, nz, tx, ty, tz;
    logic               flip, ndeg, tdeg;
  } face_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_corner = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [31:0] in_tex_u = '0, in_tex_v = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_normal_x, out_normal_y, out_normal_z;
  logic signed [15:0] out_tangent_x, out_tangent_y, out_tangent_z;
  logic out_flipped, out_normal_degenerate, out_tangent_degenerate;

  face_t faces_due[$];
  logic signed [31:0] corner_pos[2][3];
  logic signed [31:0] corner_tex[2][2];
  int errors = 0;
  int faces_seen = 0;
  int requests_sent = 0;
  int n_flat = 0;
  int n_uvflat = 0;
  longint cycles = 0;
  bit idle_on = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  triangle_face_normal_tangent_unit i_dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Timeout at %0t", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int bit_length(logic [131:0] m);
    int n;
    n = 0;
    for (int i = 0; i < 132; i++)
      if (m[i]) n = i + 1;
    return n;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Returns 0 for a zero vector, otherwise 1 with the three Q1.14 components in u.
  function automatic bit unit_vector(logic signed [131:0] v[3],
                                     output logic signed [15:0] u[3]);
    logic [131:0] m[3];
    logic [63:0] c[3], s, l, q;
    int top;
    top = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (bit_length(m[i]) > top) top = bit_length(m[i]);
    end
    if (top == 0) begin
      for (int i = 0; i < 3; i++) u[i] = '0;
      return 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      if (top > NORM_SHIFT) c[i] = 64'(m[i] >> (top - NORM_SHIFT));
      else c[i] = 64'(m[i] << (NORM_SHIFT - top));
      s = s + c[i] * c[i];
    end
    l = floor_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((c[i] << FRAC) + (l >> 1)) / l;
      if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
      u[i] = v[i] < 0 ? -16'(q) : 16'(q);
    end
    return 1'b1;
  endfunction

  function automatic face_t predict_face(logic signed [31:0] p[3],
                                         logic signed [31:0] t[2]);
    logic signed [131:0] e1[3], e2[3], nv[3], tv[3], det;
    logic signed [131:0] du1, dv1, du2, dv2;
    logic signed [15:0] u[3];
    face_t f;
    for (int i = 0; i < 3; i++) begin
      e1[i] = 132'(corner_pos[1][i]) - 132'(corner_pos[0][i]);
      e2[i] = 132'(p[i]) - 132'(corner_pos[0][i]);
    end
    du1 = 132'(corner_tex[1][0]) - 132'(corner_tex[0][0]);
    dv1 = 132'(corner_tex[1][1]) - 132'(corner_tex[0][1]);
    du2 = 132'(t[0]) - 132'(corner_tex[0][0]);
    dv2 = 132'(t[1]) - 132'(corner_tex[0][1]);
    nv[0] = e1[1] * e2[2] - e1[2] * e2[1];
    nv[1] = e1[2] * e2[0] - e1[0] * e2[2];
    nv[2] = e1[0] * e2[1] - e1[1] * e2[0];
    f.ndeg = !unit_vector(nv, u);
    f.nx = u[0];
    f.ny = u[1];
    f.nz = u[2];
    det = du1 * dv2 - du2 * dv1;
    f.tdeg = (det == 0);
    f.flip = (det > 0);
    for (int i = 0; i < 3; i++) tv[i] = dv1 * e2[i] - dv2 * e1[i];
    if (f.tdeg) for (int i = 0; i < 3; i++) u[i] = '0;
    else void'(unit_vector(tv, u));
    f.tx = u[0];
    f.ty = u[1];
    f.tz = u[2];
    return f;
  endfunction

  task automatic send_vertex(logic [1:0] corner, logic signed [31:0] p[3],
                             logic signed [31:0] t[2]);
    face_t f;
    while (idle_on && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_corner <= corner;
    in_pos_x <= p[0];
    in_pos_y <= p[1];
    in_pos_z <= p[2];
    in_tex_u <= t[0];
    in_tex_v <= t[1];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    if (corner < tfnt_pkg::CORNER_LAST) begin
      corner_pos[corner] = p;
      corner_tex[corner] = t;
    end else if (corner == tfnt_pkg::CORNER_LAST) begin
      f = predict_face(p, t);
      n_flat += f.ndeg;
      n_uvflat += f.tdeg;
      faces_due.push_back(f);
    end
  endtask

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 12;
      default: return 32'($signed($urandom_range(8)) - 4);
    endcase
  endfunction

  task automatic send_triangle(int mode);
    logic signed [31:0] p[3], t[2];
    for (int c = 0; c < 3; c++) begin
      foreach (p[i]) p[i] = rand_coord(mode);
      foreach (t[i]) t[i] = rand_coord(mode);
      send_vertex(2'(c), p, t);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (faces_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    face_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_normal_x, out_normal_y, out_normal_z, out_tangent_x, out_tangent_y,
              out_tangent_z, out_flipped, out_normal_degenerate, out_tangent_degenerate};
      if (faces_due.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = faces_due.pop_front();
        faces_seen++;
        if (got !== want) begin
          $display("%0t: expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
    out_stall <= idle_on && ($urandom_range(99) < 17);
  end

  task automatic test_extremes();
    logic signed [31:0] a[3], b[3], c[3], ta[2], tb2[2], tc[2];
    a = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000};
    b = '{32'sh7fffffff, 32'sh80000000, 32'sh80000000};
    c = '{32'sh80000000, 32'sh80000000, 32'sh7fffffff};
    ta = '{32'sh80000000, 32'sh80000000};
    tb2 = '{32'sh7fffffff, 32'sh80000000};
    tc = '{32'sh80000000, 32'sh7fffffff};
    send_vertex(2'd0, a, ta);
    send_vertex(2'd1, b, tb2);
    send_vertex(2'd2, c, tc);
    send_vertex(2'd2, c, tb2);
    send_vertex(2'd2, b, tc);
    send_vertex(2'd2, a, ta);
    send_vertex(2'd3, c, tc);
    send_vertex(2'd2, c, '{32'sh7fffffff, 32'sh7fffffff});
  endtask

  task automatic test_degenerate();
    logic signed [31:0] z[3], z2[2], one[3];
    z = '{0, 0, 0};
    z2 = '{0, 0};
    one = '{32'sh10000, 0, 0};
    send_vertex(2'd0, z, z2);
    send_vertex(2'd1, one, '{32'sh10000, 0});
    send_vertex(2'd2, '{32'sh20000, 0, 0}, '{0, 32'sh10000});
    send_vertex(2'd2, '{0, 32'sh10000, 0}, '{32'sh20000, 0});
    send_vertex(2'd2, '{0, 32'sh10000, 0}, '{0, 32'sh10000});
    send_vertex(2'd2, '{0, 32'sh10000, 0}, '{0, -32'sh10000});
    send_vertex(2'd2, z, z2);
    send_vertex(2'd2, '{0, 0, 32'sh10000}, '{32'sh10000, 32'sh10000});
    wait_drained();
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 80) send_triangle($urandom_range(2));
      else send_vertex(2'($urandom_range(3)) | 2'd2,
                       '{rand_coord(0), rand_coord(1), rand_coord(2)},
                       '{rand_coord(2), rand_coord(0)});
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_degenerate();
    test_random(230);
    idle_on = 1'b0;
    test_random(60);
    idle_on = 1'b1;
    test_random(170);
    wait_drained();
    repeat (400) @(posedge clk);
    $display("Sent %0d requests, checked %0d faces (%0d flat, %0d with flat UVs).",
             requests_sent, faces_seen, n_flat, n_uvflat);
    if (errors == 0 && faces_due.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
